### src/lsrc_pkg.sv
`default_nettype none
package lsrc_pkg;
  localparam int MaskW = 64;
  localparam int PortW = 6;
  localparam int ValW = 13;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 6;
  localparam int InDataW = 88;
  localparam int OutDataW = 8;
  localparam int OutUserW = 2;
  localparam int DivSteps = 6;

  localparam logic [CfgIdxW-1:0] REG_GPUS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEAVES = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GROUPS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GLINKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPINES = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LPP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VCS = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd7;

  typedef enum logic [1:0] {KIND_NONE, KIND_SPINE, KIND_GPU, KIND_LEAF} kind_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic pick_last;
  } sts_t;
endpackage
`default_nettype wire

### src/lsrc_div.sv
`default_nettype none
module lsrc_div (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [5:0] dvd_a,
  input  wire logic [3:0] dvd_b,
  input  wire logic [3:0] dvs,
  output logic [5:0]      q_a,
  output logic [3:0]      r_a,
  output logic [3:0]      r_b,
  output logic            done
);
  import lsrc_pkg::*;

  logic [2:0] cnt_r;
  logic       busy_r, done_r;
  logic [5:0] qa_r, qb_r;
  logic [3:0] ra_r, rb_r;
  logic [4:0] ta, tb;
  logic       ga, gb;

  // one quotient bit per cycle for both lanes
  assign ta = {ra_r, qa_r[5]};
  assign tb = {rb_r, qb_r[5]};
  assign ga = ta >= {1'b0, dvs};
  assign gb = tb >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r <= dvd_a;
      qb_r <= {2'b00, dvd_b};
      ra_r <= '0;
      rb_r <= '0;
    end else if (busy_r) begin
      qa_r <= {qa_r[4:0], ga};
      qb_r <= {qb_r[4:0], gb};
      ra_r <= ga ? 4'(ta - {1'b0, dvs}) : ta[3:0];
      rb_r <= gb ? 4'(tb - {1'b0, dvs}) : tb[3:0];
    end
  end

  assign q_a = qa_r;
  assign r_a = ra_r;
  assign r_b = rb_r;
  assign done = done_r;
endmodule
`default_nettype wire

### src/lsrc_ctrl.sv
`default_nettype none
module lsrc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire lsrc_pkg::sts_t sts,
  output lsrc_pkg::cmd_t     cmd
);
  import lsrc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_DIV, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_S1;
      end
      ST_S1: begin
        cmd.st1 = 1'b1;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        cmd.st2 = 1'b1;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        cmd.st3 = 1'b1;
        state_nxt = ST_S4;
      end
      ST_S4: begin
        cmd.st4 = 1'b1;
        state_nxt = ST_S5;
      end
      ST_S5: begin
        cmd.st5 = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.pick_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### src/lsrc_dp.sv
`default_nettype none
module lsrc_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lsrc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [lsrc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic [lsrc_pkg::InDataW-1:0]   in_tdata,
  input  wire lsrc_pkg::cmd_t                 cmd,
  output lsrc_pkg::sts_t                      sts,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lsrc_pkg::OutDataW-1:0]       out_tdata,
  output logic                                out_tlast,
  output logic [lsrc_pkg::OutUserW-1:0]       out_tuser
);
  import lsrc_pkg::*;

  function automatic logic [MaskW-1:0] low1(input logic [MaskW-1:0] m);
    return m & (~m + MaskW'(1));
  endfunction

  logic [4:0] gpr_r, gcnt_r;
  logic [3:0] lpg_r, vcc_r;
  logic [5:0] glc_r, spc_r;
  logic [2:0] lpp_r;
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_r <= 5'd8;
      lpg_r <= 4'd4;
      gcnt_r <= 5'd1;
      glc_r <= 6'd18;
      spc_r <= 6'd0;
      lpp_r <= 3'd1;
      vcc_r <= 4'd1;
      mode_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GPUS: gpr_r <= cfg_wdata[4:0];
        REG_LEAVES: lpg_r <= cfg_wdata[3:0];
        REG_GROUPS: gcnt_r <= cfg_wdata[4:0];
        REG_GLINKS: glc_r <= cfg_wdata;
        REG_SPINES: spc_r <= cfg_wdata;
        REG_LPP: lpp_r <= cfg_wdata[2:0];
        REG_VCS: vcc_r <= cfg_wdata[3:0];
        REG_MODE: mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [4:0] hg_r, hn_r;
  logic [3:0] dg_r, dn_r;
  logic [MaskW-1:0] lnk_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hg_r <= in_tdata[4:0];
      hn_r <= in_tdata[9:5];
      dg_r <= in_tdata[13:10];
      dn_r <= in_tdata[17:14];
      lnk_r <= in_tdata[81:18];
    end
  end

  logic [5:0] q;
  logic [3:0] r_c, r_d;

  lsrc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dvd_a(glc_r), .dvd_b(dn_r), .dvs(lpg_r),
    .q_a(q), .r_a(r_c), .r_b(r_d), .done(sts.div_done)
  );

  // stage 1: classify node, link split for the selected leaf
  kind_t kind_c, kind_r;
  logic [4:0] hnmg;
  logic [3:0] sw_c, minsr_r;
  logic [5:0] nl_r, nl0_r;
  logic [9:0] swq_r;
  logic [8:0] sp_r;
  logic [6:0] lp_r;
  logic local_r;

  assign hnmg = hn_r - gpr_r;

  always_comb begin
    kind_c = KIND_NONE;
    if (vcc_r == '0 || lpg_r == '0) kind_c = KIND_NONE;
    else if (spc_r != '0 && hg_r == gcnt_r)
      kind_c = ({1'b0, hn_r} < spc_r) ? KIND_SPINE : KIND_NONE;
    else if (hg_r >= gcnt_r) kind_c = KIND_NONE;
    else if (hn_r < gpr_r) kind_c = KIND_GPU;
    else if (hnmg < {1'b0, lpg_r}) kind_c = KIND_LEAF;
  end

  assign sw_c = (kind_c == KIND_GPU) ? r_d : hnmg[3:0];

  always_ff @(posedge clk) begin
    if (cmd.st1) begin
      kind_r <= kind_c;
      nl_r <= q + {5'd0, sw_c < r_c};
      nl0_r <= q + {5'd0, r_c != '0};
      swq_r <= 10'(sw_c * q);
      minsr_r <= (sw_c < r_c) ? sw_c : r_c;
      sp_r <= 9'(spc_r * lpp_r);
      lp_r <= 7'(lpg_r * lpp_r);
      local_r <= hg_r == {1'b0, dg_r};
    end
  end

  // stage 2: port offsets
  logic [9:0] base_r, dnl_r;
  logic [10:0] io_r, gn0_r, dglp_r;
  logic [11:0] nglp_r;

  always_ff @(posedge clk) begin
    if (cmd.st2) begin
      base_r <= swq_r + 10'(minsr_r);
      io_r <= 11'(gpr_r * nl_r);
      dnl_r <= 10'(dn_r * nl_r);
      gn0_r <= 11'(gpr_r * nl0_r);
      dglp_r <= 11'(dg_r * lp_r);
      nglp_r <= 12'(gcnt_r * lp_r);
    end
  end

  // stage 3: port ranges and radix
  logic [ValW-1:0] xo_c, rad_c, lim_c, alo_c, ahi_c, blo_c, bhi_c;
  logic [ValW-1:0] xo_r, lim_r, alo_r, ahi_r, blo_r, bhi_r;

  always_comb begin
    xo_c = ValW'(io_r) + ValW'(lpg_r) - ValW'(1);
    rad_c = ValW'(gn0_r) + ValW'(lpg_r) - ValW'(1) + ValW'(sp_r);
    if (spc_r == '0 && mode_r[1] && gcnt_r > 5'd1) rad_c = rad_c + ValW'(gcnt_r);
    lim_c = '0;
    alo_c = '0;
    ahi_c = '0;
    blo_c = '0;
    bhi_c = '0;
    case (kind_r)
      KIND_GPU: begin
        lim_c = ValW'(glc_r);
        alo_c = ValW'(base_r);
        ahi_c = ValW'(base_r) + ValW'(nl_r);
      end
      KIND_SPINE: begin
        lim_c = ValW'(nglp_r);
        alo_c = ValW'(dglp_r);
        ahi_c = ValW'(dglp_r) + ValW'(lp_r);
      end
      KIND_LEAF: begin
        lim_c = rad_c;
        if (local_r) begin
          alo_c = ValW'(dnl_r);
          ahi_c = ValW'(dnl_r) + ValW'(nl_r);
          blo_c = ValW'(io_r);
          bhi_c = xo_c;
        end else if (spc_r != '0) begin
          alo_c = xo_c;
          ahi_c = xo_c + ValW'(sp_r);
        end else begin
          alo_c = xo_c;
          ahi_c = rad_c;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.st3) begin
      xo_r <= xo_c;
      lim_r <= lim_c;
      alo_r <= alo_c;
      ahi_r <= ahi_c;
      blo_r <= blo_c;
      bhi_r <= bhi_c;
    end
  end

  // stage 4: per-port range masks
  logic [MaskW-1:0] ma_c, mb_c, mz_c, ok_c, ma_r, mb_r, mz_r, ok_r;

  always_comb begin
    for (int p = 0; p < MaskW; p++) begin
      mz_c[p] = lnk_r[p] && (ValW'(p) < lim_r);
      ma_c[p] = mz_c[p] && (ValW'(p) >= alo_r) && (ValW'(p) < ahi_r);
      mb_c[p] = mz_c[p] && (ValW'(p) >= blo_r) && (ValW'(p) < bhi_r);
      ok_c[p] = ma_c[p] && (((ValW'(p) - xo_r) == ValW'(dg_r)) ||
                            ((ValW'(p) - xo_r) != ValW'(hg_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st4) begin
      ma_r <= ma_c;
      mb_r <= mb_c;
      mz_r <= mz_c;
      ok_r <= ok_c;
    end
  end

  // stage 5: rule selection
  logic [MaskW-1:0] m_c, mask_r;
  logic fb_c, fb_r;

  always_comb begin
    m_c = '0;
    fb_c = 1'b0;
    case (kind_r)
      KIND_GPU: begin
        if (mode_r[0]) m_c = mz_r;
        else if (local_r && ma_r != '0) m_c = low1(ma_r);
        else m_c = low1(mz_r);
      end
      KIND_SPINE: m_c = ma_r;
      KIND_LEAF: begin
        if (local_r) m_c = ma_r | mb_r;
        else if (spc_r != '0) m_c = ma_r;
        else if (mode_r[1]) begin
          m_c = mode_r[0] ? ok_r : low1(ok_r);
          if (m_c == '0) m_c = low1(ma_r);
        end
        if (m_c == '0) begin
          m_c = low1(mz_r);
          fb_c = mz_r != '0;
        end
      end
      default: ;
    endcase
  end

  // emit: one candidate per transaction, lowest port first
  logic [PortW-1:0] pidx, out_port_r;
  logic [MaskW-1:0] rest;
  logic out_v_r, out_last_r, out_nr_r, out_fb_r;

  always_comb begin
    pidx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (mask_r[i]) pidx = PortW'(i);
    end
  end

  assign rest = mask_r & (mask_r - MaskW'(1));
  assign sts.pick_last = rest == '0;
  assign sts.out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.st5) begin
      mask_r <= m_c;
      fb_r <= fb_c;
    end else if (cmd.emit) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_port_r <= pidx;
      out_last_r <= rest == '0;
      out_nr_r <= mask_r == '0;
      out_fb_r <= fb_r && (mask_r != '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {2'b00, out_port_r};
  assign out_tlast = out_last_r;
  assign out_tuser = {out_fb_r, out_nr_r};

`ifndef SYNTHESIS
  a_noroute_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_nr_r |-> out_last_r && out_port_r == '0 && !out_fb_r)
    else $error("no-route result malformed");
  a_fallback_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_fb_r |-> out_last_r)
    else $error("fallback result not last");
  a_mask_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.pick_last |=> mask_r == '0)
    else $error("candidates left after last");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");
`endif
endmodule
`default_nettype wire

### src/leaf_spine_route_compute.sv
// Route computation for a GPU / leaf / spine fabric.
// in_* channel: one request per transaction; in_tdata holds here_group,
//   here_node, dest_group, dest_node, port_connected (lowest bits first).
// out_* channel: one candidate port per transaction in ascending order;
//   out_tlast marks the final candidate, out_tuser flags no route and
//   first-connected-port fallback. A no-route answer is a single transaction.
// cfg_*: register write by index, taken whenever cfg_we is high; the user must
//   write only while no request is in flight, as the block does not enforce it.
// Sequence: accept, a start state, the shared link-split divider (6 steps
//   and a done flag), 5 datapath stages, then one candidate per cycle while
//   out_tready allows. The output register and the one-port-per-cycle
//   emitter set the throughput.
// A new request is taken as soon as the last candidate sits in the output
//   register. A stall on out_tready holds the emitter with nothing lost.
// Reset (synchronous, rst_n low) returns the registers to their defaults
//   and empties the output register.
`default_nettype none
module leaf_spine_route_compute (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lsrc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lsrc_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // here_group[4:0] here_node[9:5] dest_group[13:10] dest_node[17:14]
  // port_connected[81:18], zero pad
  input  wire logic [lsrc_pkg::InDataW-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // out_port[5:0], zero pad
  output logic [lsrc_pkg::OutDataW-1:0]      out_tdata,
  output logic                               out_tlast,
  // no_route[0] fallback_used[1]
  output logic [lsrc_pkg::OutUserW-1:0]      out_tuser
);
  import lsrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsrc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  lsrc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tdata(in_tdata), .cmd(cmd), .sts(sts),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );
endmodule
`default_nettype wire
